// ===== hw/rtl/nfed_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the nearest-floor elevator dispatcher.
// No dependencies.
package nfed_pkg;

  localparam int FLOOR_W    = 4;   // floor number field width
  localparam int IN_DATA_W  = 8;   // s_tdata: floor, zero padded to a byte
  localparam int OUT_DATA_W = 16;  // m_tdata: result fields, zero padded

endpackage

// ===== hw/rtl/nearest_floor_elevator_dispatch.sv =====
`timescale 1ns / 1ps
// Nearest-floor elevator dispatcher: sorted request queue held in one
// synchronous RAM, walked by a sequencer. Depends on nfed_pkg.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+---------------------------------------
//  s_*     | in  | s_tvalid/s_tready | s_tuser = mode, s_tdata = floor
//  m_*     | out | m_tvalid/m_tready | current, target, door, count, dropped
//
// One item at a time. N is the queue fill, P the insert position. A request
// scans the entries up to P (P + 1 of them, or N when it goes last), shifts
// the N - P entries behind P up and writes the new one; a bad floor or a
// full queue goes straight to the result. A tick with nothing to pop checks
// and moves the car; it may pop a target, swap it back and pop again.
// Reset (synchronous, rst high) empties the queue, parks the car at floor 1.
// The next transaction is taken while a result still waits in the output
// register; a stalled m_tready holds the sequencer only at its final step.
module nearest_floor_elevator_dispatch
  import nfed_pkg::*;
#(
  parameter int FLOOR_COUNT = 8,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [3:0] floor
  input  logic [0:0]            s_tuser,   // [0] mode (0 request, 1 tick)
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [3:0] current_floor, [7:4] target_floor,
                                           // [8] door_cycle, [12:9] queue_count,
                                           // [13] request_dropped
);

  localparam int PW = $clog2(FLOOR_COUNT);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int EW = FLOOR_W + PW;

  typedef struct packed {
    logic [FLOOR_W-1:0] fl;
    logic [PW-1:0]      pr;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_POP_FRONT, S_POP_SH, S_T_CHECK, S_T_CMP, S_INS_START,
    S_SCAN, S_SHIFT_UP, S_INS_WR, S_T_MOVE, S_FIN
  } state_t;

  state_t             state;
  logic [CW-1:0]      cnt;
  logic [FLOOR_W-1:0] car;
  logic [FLOOR_W-1:0] serv_fl;
  logic [PW-1:0]      serv_pr;
  logic [FLOOR_W-1:0] in_fl;
  logic [PW-1:0]      in_pr;
  logic [CW-1:0]      pos;
  logic [CW-1:0]      k;
  logic               is_tick;
  logic               swap;
  logic               dropped;

  // queue RAM
  logic [EW-1:0] mem [QUEUE_DEPTH];
  entry_t        q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        wr_data;

  logic               accept;
  logic [FLOOR_W-1:0] req_fl;
  logic               req_ok;
  logic [FLOOR_W-1:0] req_dist;
  state_t             pop_ret;
  state_t             ins_ret;
  logic               arrive;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign req_fl   = s_tdata[FLOOR_W-1:0];
  assign req_ok   = (req_fl != '0) && (req_fl <= FLOOR_W'(FLOOR_COUNT)) &&
                    (cnt < CW'(QUEUE_DEPTH));
  assign req_dist = (req_fl >= car) ? (req_fl - car) : (car - req_fl);
  assign pop_ret  = swap ? S_INS_START : S_T_CHECK;
  assign ins_ret  = is_tick ? S_T_MOVE : S_FIN;
  assign arrive   = is_tick && (serv_fl != '0) && (serv_fl == car);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = q;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (s_tuser[0]) rd_en = (serv_fl == '0) && (cnt != '0);
          else            rd_en = req_ok && (cnt != '0);
        end
      end
      S_POP_FRONT: begin
        rd_en   = cnt > CW'(1);
        rd_addr = AW'(1);
      end
      S_POP_SH: begin
        wr_en   = 1'b1;
        wr_addr = AW'(k - CW'(1));
        rd_en   = (k + CW'(1)) < cnt;
        rd_addr = AW'(k + CW'(1));
      end
      S_T_CHECK: begin
        rd_en = (serv_fl != '0) && (serv_fl != car) && (cnt != '0);
      end
      S_INS_START: begin
        rd_en = cnt != '0;
      end
      S_SCAN: begin
        if (q.pr < in_pr) begin
          rd_en   = (pos + CW'(1)) < cnt;
          rd_addr = AW'(pos + CW'(1));
        end else if (!(q.pr == in_pr && q.fl == in_fl)) begin
          rd_en   = 1'b1;
          rd_addr = AW'(cnt - CW'(1));
        end
      end
      S_SHIFT_UP: begin
        wr_en   = 1'b1;
        wr_addr = AW'(k);
        rd_en   = (k - CW'(1)) > pos;
        rd_addr = AW'(k - CW'(2));
      end
      S_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = AW'(pos);
        wr_data = '{fl: in_fl, pr: in_pr};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) q <= entry_t'(mem[rd_addr]);
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      car      <= FLOOR_W'(1);
      serv_fl  <= '0;
      serv_pr  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // S_FIN reloads the output register itself
      if (m_tvalid && m_tready && state != S_FIN) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            is_tick <= s_tuser[0];
            swap    <= 1'b0;
            dropped <= 1'b0;
            if (s_tuser[0]) begin
              state <= ((serv_fl == '0) && (cnt != '0)) ? S_POP_FRONT : S_T_CHECK;
            end else if (!req_ok) begin
              dropped <= 1'b1;
              state   <= S_FIN;
            end else begin
              in_fl <= req_fl;
              in_pr <= PW'(req_dist);
              pos   <= '0;
              state <= (cnt == '0) ? S_INS_WR : S_SCAN;
            end
          end
        end
        S_POP_FRONT: begin
          serv_fl <= q.fl;
          serv_pr <= q.pr;
          k       <= CW'(1);
          if (cnt > CW'(1)) begin
            state <= S_POP_SH;
          end else begin
            cnt   <= cnt - CW'(1);
            state <= pop_ret;
          end
        end
        S_POP_SH: begin
          if ((k + CW'(1)) < cnt) begin
            k <= k + CW'(1);
          end else begin
            cnt   <= cnt - CW'(1);
            state <= pop_ret;
          end
        end
        S_T_CHECK: begin
          if ((serv_fl != '0) && (serv_fl != car))
            state <= (cnt != '0) ? S_T_CMP : S_T_MOVE;
          else
            state <= S_FIN;
        end
        S_T_CMP: begin
          // q still holds the queue front; swap the held target back in
          if (serv_pr > q.pr) begin
            in_fl <= serv_fl;
            in_pr <= serv_pr;
            swap  <= 1'b1;
            state <= S_POP_FRONT;
          end else begin
            state <= S_T_MOVE;
          end
        end
        S_INS_START: begin
          pos   <= '0;
          state <= (cnt == '0) ? S_INS_WR : S_SCAN;
        end
        S_SCAN: begin
          if (q.pr < in_pr) begin
            pos <= pos + CW'(1);
            if ((pos + CW'(1)) >= cnt) state <= S_INS_WR;
          end else if (q.pr == in_pr && q.fl == in_fl) begin
            dropped <= !is_tick;
            state   <= ins_ret;
          end else begin
            k     <= cnt;
            state <= S_SHIFT_UP;
          end
        end
        S_SHIFT_UP: begin
          if ((k - CW'(1)) > pos) k <= k - CW'(1);
          else                    state <= S_INS_WR;
        end
        S_INS_WR: begin
          cnt   <= cnt + CW'(1);
          state <= ins_ret;
        end
        S_T_MOVE: begin
          if (car < serv_fl)      car <= car + FLOOR_W'(1);
          else if (car > serv_fl) car <= car - FLOOR_W'(1);
          state <= S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            if (arrive) serv_fl <= '0;
            m_tdata <= {2'b00, dropped, 4'(cnt), arrive,
                        arrive ? FLOOR_W'(0) : serv_fl, car};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
